>>> sv/lrbc_pkg.sv
// ============================================================================
// lrbc_pkg: shared types and constants for the lidar ring board center block
// Widths, ring storage layout, register indexes and sequencer states.
// ============================================================================
`default_nettype none

package lrbc_pkg;

    localparam int RING_COUNT = 80;
    localparam int COORD_BITS = 18;

    localparam int RING_AW  = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
    localparam int RING_IW  = 7;                    // ring_index field width
    localparam int CFG_DW   = 18;
    localparam int CFG_IW   = 3;
    localparam int PROD_W   = 16 + COORD_BITS;      // a*x product
    localparam int RES_W    = PROD_W + 2;           // plane residual
    localparam int AR_W     = 27;                   // residual magnitude kept for squaring
    localparam int ARSQ_W   = 2 * AR_W;
    localparam int NSQ_W    = 31;                   // one normal component squared
    localparam int N2_W     = NSQ_W + 2;
    localparam int TOL2_W   = 20;
    localparam int RHS_W    = TOL2_W + N2_W;
    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int DSQ_W    = 2 * DIFF_W;
    localparam int D2_W     = DSQ_W + 2;
    localparam int WIN_W    = 14;                   // width window bounds, signed
    localparam int WSQ_W    = 2 * WIN_W;
    localparam int USED_W   = 8;
    localparam int USED_MAX = 127;
    localparam int SUM_W    = COORD_BITS + USED_W + 2;
    localparam int DIV_W    = USED_W + 1;           // divisor 2*used
    localparam int REM_W    = DIV_W + 1;
    localparam int DIVC_W   = $clog2(SUM_W + 1);

    typedef enum logic [CFG_IW-1:0] {
        CFG_PLANE_A   = 3'd0,
        CFG_PLANE_B   = 3'd1,
        CFG_PLANE_C   = 3'd2,
        CFG_PLANE_OFS = 3'd3,
        CFG_PLANE_TOL = 3'd4,
        CFG_WIDTH     = 3'd5,
        CFG_WIDTH_TOL = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    typedef struct packed {
        logic [1:0] cnt;
        point_t     low;
        point_t     sec;
        point_t     high;
    } ring_entry_t;

    localparam int ENTRY_W = $bits(ring_entry_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SQ,
        ST_UPD,
        ST_WINIT,
        ST_WRD,
        ST_WDIFF,
        ST_WSQ,
        ST_WACC,
        ST_DINIT,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> sv/lrbc_if.sv
// ============================================================================
// lrbc_point_if / lrbc_center_if: valid/ready channels of the block
// Point stream in, board center result out.
// ============================================================================
`default_nettype none

interface lrbc_point_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lrbc_pkg::COORD_BITS-1:0] point_x;
    logic signed [lrbc_pkg::COORD_BITS-1:0] point_y;
    logic signed [lrbc_pkg::COORD_BITS-1:0] point_z;
    logic [lrbc_pkg::RING_IW-1:0]           ring_index;
    logic                                  point_present;
    logic                                  frame_end;

    modport source (output valid, point_x, point_y, point_z, ring_index,
                    point_present, frame_end, input ready);
    modport sink   (input valid, point_x, point_y, point_z, ring_index,
                    point_present, frame_end, output ready);
endinterface

interface lrbc_center_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lrbc_pkg::COORD_BITS-1:0] center_x;
    logic signed [lrbc_pkg::COORD_BITS-1:0] center_y;
    logic [6:0]                             rings_used;
    logic                                  found;

    modport source (output valid, center_x, center_y, rings_used, found,
                    input ready);
    modport sink   (input valid, center_x, center_y, rings_used, found,
                    output ready);
endinterface

`default_nettype wire

>>> sv/lrbc_ram.sv
// ============================================================================
// lrbc_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module lrbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/lidar_ring_board_center_core.sv
// ============================================================================
// lidar_ring_board_center_core: board center from ring-sorted lidar points
// Keeps per-ring extreme plane points in RAM and averages board edge midpoints.
// ============================================================================
// Usage:
//   pt  : point transactions (x, y, z, ring, point_present, frame_end).
//   ctr : one result transaction per frame_end (center, rings used, found).
//   cfg : write port, cfg_we/cfg_index/cfg_data, write only while idle.
// Each point passes through the RAM read of its ring entry, the plane
// products, the residual sum, the squaring, then the compare and write-back
// of the updated entry. The ring RAM has one read and one write port and one
// point is in flight at a time, so no two accesses to an entry overlap.
// A frame_end transaction adds a setup step, the ring walk (for each ring the
// RAM read, the edge difference and midpoint, the squaring and the
// accumulate), a load step and a bit-serial divider of SUM_W (28) quotient
// bits, and the load of the result register.
// Reset clears all ring counts through per-ring valid bits; no RAM clearing
// pass is needed. The valid bits are cleared again after each frame.
// The result sits in an output register; points keep being accepted while
// it waits. A following frame_end holds in its last state until the
// register is taken.
// ============================================================================
`default_nettype none

module lidar_ring_board_center_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    lrbc_point_if.sink                         pt,
    lrbc_center_if.source                      ctr,
    input  wire logic                          cfg_we,
    input  wire logic [lrbc_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [lrbc_pkg::CFG_DW-1:0]   cfg_data
);

    localparam int CB = lrbc_pkg::COORD_BITS;
    localparam int AW = lrbc_pkg::RING_AW;

    // configuration
    logic signed [15:0] plane_a_reg, plane_b_reg, plane_c_reg;
    logic signed [17:0] plane_ofs_reg;
    logic [9:0]         plane_tol_reg, width_tol_reg;
    logic [11:0]        width_reg;

    lrbc_pkg::state_t state_reg, state_next;

    // item registers
    lrbc_pkg::point_t                p_reg;
    logic                            present_reg, frame_end_reg, ring_ok_reg;
    logic [AW-1:0]                   ring_reg;
    lrbc_pkg::ring_entry_t           entry_reg;
    logic signed [lrbc_pkg::PROD_W-1:0] ax_reg, by_reg, cz_reg;
    logic [lrbc_pkg::NSQ_W-1:0]      aa_reg, bb_reg, cc_reg;
    logic [lrbc_pkg::TOL2_W-1:0]     tol2_reg;
    logic signed [lrbc_pkg::RES_W-1:0] res_reg;
    logic [lrbc_pkg::N2_W-1:0]       n2_reg;
    logic                            ar_big_reg;
    logic [lrbc_pkg::ARSQ_W-1:0]     arsq_reg;
    logic [lrbc_pkg::RHS_W-1:0]      rhs_reg;

    localparam int RING_COUNT_W = lrbc_pkg::RING_COUNT;
    logic [RING_COUNT_W-1:0]         valid_reg;

    // walk registers
    logic [AW-1:0]                    walk_idx_reg;
    logic                             walk_ok_reg;
    logic signed [lrbc_pkg::DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [lrbc_pkg::DIFF_W-1:0] mx_reg, my_reg;
    logic [lrbc_pkg::DSQ_W-1:0]       dxx_reg, dyy_reg, dzz_reg;
    logic signed [lrbc_pkg::WIN_W-1:0] lo_reg;
    logic [lrbc_pkg::WSQ_W-1:0]       lo2_reg, hi2_reg;
    logic signed [lrbc_pkg::SUM_W-1:0] sum_x_reg, sum_y_reg;
    logic [lrbc_pkg::USED_W-1:0]      used_reg;

    // divider
    logic [lrbc_pkg::SUM_W-1:0]  qx_reg, qy_reg;
    logic [lrbc_pkg::REM_W-1:0]  remx_reg, remy_reg;
    logic [lrbc_pkg::DIV_W-1:0]  divisor_reg;
    logic                        negx_reg, negy_reg;
    logic [lrbc_pkg::DIVC_W-1:0] divc_reg;

    // output register
    logic                        out_valid_reg;
    logic signed [CB-1:0]        out_x_reg, out_y_reg;
    logic [6:0]                  out_used_reg;
    logic                        out_found_reg;

    // RAM
    logic                        ram_we;
    logic [AW-1:0]               ram_raddr;
    lrbc_pkg::ring_entry_t       ram_rdata, upd_entry;

    lrbc_ram #(
        .WIDTH (lrbc_pkg::ENTRY_W),
        .DEPTH (lrbc_pkg::RING_COUNT)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ring_reg),
        .wdata (upd_entry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // arithmetic terms
    // ------------------------------------------------------------------
    localparam int PW = lrbc_pkg::PROD_W;
    logic signed [PW-1:0] ax_w, by_w, cz_w;
    logic signed [31:0]   aa_w, bb_w, cc_w;
    logic [lrbc_pkg::RES_W-1:0] ar_w;
    logic                 on_plane;
    logic                 in_range;
    logic [lrbc_pkg::D2_W-1:0] d2_w;
    logic                 edge_ok;

    assign ax_w = PW'(plane_a_reg) * PW'(p_reg.x);
    assign by_w = PW'(plane_b_reg) * PW'(p_reg.y);
    assign cz_w = PW'(plane_c_reg) * PW'(p_reg.z);
    assign aa_w = 32'(plane_a_reg) * 32'(plane_a_reg);
    assign bb_w = 32'(plane_b_reg) * 32'(plane_b_reg);
    assign cc_w = 32'(plane_c_reg) * 32'(plane_c_reg);
    assign ar_w = res_reg[lrbc_pkg::RES_W-1] ? lrbc_pkg::RES_W'(-res_reg)
                                             : lrbc_pkg::RES_W'(res_reg);
    assign on_plane = !ar_big_reg && (arsq_reg < lrbc_pkg::ARSQ_W'(rhs_reg));
    assign in_range = ({1'b0, pt.ring_index} < (lrbc_pkg::RING_IW + 1)'(lrbc_pkg::RING_COUNT));

    assign d2_w = lrbc_pkg::D2_W'(dxx_reg) + lrbc_pkg::D2_W'(dyy_reg)
                + lrbc_pkg::D2_W'(dzz_reg);
    assign edge_ok = (lo_reg[lrbc_pkg::WIN_W-1] || (d2_w > lrbc_pkg::D2_W'(lo2_reg)))
                  && (d2_w < lrbc_pkg::D2_W'(hi2_reg));

    // ring entry update for an accepted plane point
    always_comb
    begin
        lrbc_pkg::ring_entry_t e;
        logic [1:0] n;
        e = entry_reg;
        n = valid_reg[ring_reg] ? entry_reg.cnt : 2'd0;
        if (n == 2'd0)
        begin
            e.low  = p_reg;
            e.high = p_reg;
            e.cnt  = 2'd1;
        end
        else
        begin
            if ($signed(p_reg.y) < $signed(entry_reg.low.y))
            begin
                e.sec = entry_reg.low;
                e.low = p_reg;
            end
            else if ((n == 2'd1) || ($signed(p_reg.y) < $signed(entry_reg.sec.y)))
            begin
                e.sec = p_reg;
            end
            if ($signed(p_reg.y) >= $signed(entry_reg.high.y))
            begin
                e.high = p_reg;
            end
            e.cnt = 2'd2;
        end
        upd_entry = e;
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrbc_pkg::ST_IDLE:  if (pt.valid) state_next = lrbc_pkg::ST_MUL;
            lrbc_pkg::ST_MUL:   state_next = lrbc_pkg::ST_SUM;
            lrbc_pkg::ST_SUM:   state_next = lrbc_pkg::ST_SQ;
            lrbc_pkg::ST_SQ:    state_next = lrbc_pkg::ST_UPD;
            lrbc_pkg::ST_UPD:   state_next = frame_end_reg ? lrbc_pkg::ST_WINIT
                                                           : lrbc_pkg::ST_IDLE;
            lrbc_pkg::ST_WINIT: state_next = lrbc_pkg::ST_WRD;
            lrbc_pkg::ST_WRD:   state_next = lrbc_pkg::ST_WDIFF;
            lrbc_pkg::ST_WDIFF: state_next = lrbc_pkg::ST_WSQ;
            lrbc_pkg::ST_WSQ:   state_next = lrbc_pkg::ST_WACC;
            lrbc_pkg::ST_WACC:  state_next = (walk_idx_reg == AW'(lrbc_pkg::RING_COUNT - 1))
                                             ? lrbc_pkg::ST_DINIT : lrbc_pkg::ST_WRD;
            lrbc_pkg::ST_DINIT: state_next = lrbc_pkg::ST_DIV;
            lrbc_pkg::ST_DIV:   if (divc_reg == lrbc_pkg::DIVC_W'(lrbc_pkg::SUM_W - 1))
                                    state_next = lrbc_pkg::ST_DONE;
            lrbc_pkg::ST_DONE:  if (!out_valid_reg) state_next = lrbc_pkg::ST_IDLE;
            default:            state_next = lrbc_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        pt.ready  = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = walk_idx_reg;
        case (state_reg)
            lrbc_pkg::ST_IDLE:
            begin
                pt.ready  = 1'b1;
                ram_raddr = in_range ? pt.ring_index[AW-1:0] : '0;
            end
            lrbc_pkg::ST_UPD:
                ram_we = present_reg && ring_ok_reg && on_plane;
            default:
                ram_we = 1'b0;
        endcase
    end

    assign ctr.valid      = out_valid_reg;
    assign ctr.center_x   = out_x_reg;
    assign ctr.center_y   = out_y_reg;
    assign ctr.rings_used = out_used_reg;
    assign ctr.found      = out_found_reg;

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrbc_pkg::ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            plane_a_reg   <= 16'sd16384;
            plane_b_reg   <= '0;
            plane_c_reg   <= '0;
            plane_ofs_reg <= '0;
            plane_tol_reg <= 10'd50;
            width_reg     <= 12'd600;
            width_tol_reg <= 10'd50;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                valid_reg[ring_reg] <= 1'b1;
            end
            if (state_reg == lrbc_pkg::ST_DONE && !out_valid_reg)
            begin
                valid_reg     <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (ctr.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (lrbc_pkg::cfg_idx_t'(cfg_index))
                    lrbc_pkg::CFG_PLANE_A:   plane_a_reg   <= cfg_data[15:0];
                    lrbc_pkg::CFG_PLANE_B:   plane_b_reg   <= cfg_data[15:0];
                    lrbc_pkg::CFG_PLANE_C:   plane_c_reg   <= cfg_data[15:0];
                    lrbc_pkg::CFG_PLANE_OFS: plane_ofs_reg <= cfg_data;
                    lrbc_pkg::CFG_PLANE_TOL: plane_tol_reg <= cfg_data[9:0];
                    lrbc_pkg::CFG_WIDTH:     width_reg     <= cfg_data[11:0];
                    lrbc_pkg::CFG_WIDTH_TOL: width_tol_reg <= cfg_data[9:0];
                    default:                 plane_a_reg   <= plane_a_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lrbc_pkg::ST_IDLE:
            begin
                p_reg.x       <= pt.point_x;
                p_reg.y       <= pt.point_y;
                p_reg.z       <= pt.point_z;
                present_reg   <= pt.point_present;
                frame_end_reg <= pt.frame_end;
                ring_ok_reg   <= in_range;
                ring_reg      <= in_range ? pt.ring_index[AW-1:0] : '0;
            end
            lrbc_pkg::ST_MUL:
            begin
                entry_reg <= ram_rdata;
                ax_reg    <= ax_w;
                by_reg    <= by_w;
                cz_reg    <= cz_w;
                aa_reg    <= aa_w[lrbc_pkg::NSQ_W-1:0];
                bb_reg    <= bb_w[lrbc_pkg::NSQ_W-1:0];
                cc_reg    <= cc_w[lrbc_pkg::NSQ_W-1:0];
                tol2_reg  <= lrbc_pkg::TOL2_W'(plane_tol_reg)
                           * lrbc_pkg::TOL2_W'(plane_tol_reg);
            end
            lrbc_pkg::ST_SUM:
            begin
                res_reg <= lrbc_pkg::RES_W'(ax_reg) + lrbc_pkg::RES_W'(by_reg)
                         + lrbc_pkg::RES_W'(cz_reg) + lrbc_pkg::RES_W'(plane_ofs_reg);
                n2_reg  <= lrbc_pkg::N2_W'(aa_reg) + lrbc_pkg::N2_W'(bb_reg)
                         + lrbc_pkg::N2_W'(cc_reg);
            end
            lrbc_pkg::ST_SQ:
            begin
                ar_big_reg <= (ar_w[lrbc_pkg::RES_W-1:lrbc_pkg::AR_W] != '0);
                arsq_reg   <= lrbc_pkg::ARSQ_W'(ar_w[lrbc_pkg::AR_W-1:0])
                            * lrbc_pkg::ARSQ_W'(ar_w[lrbc_pkg::AR_W-1:0]);
                rhs_reg    <= lrbc_pkg::RHS_W'(tol2_reg) * lrbc_pkg::RHS_W'(n2_reg);
            end
            lrbc_pkg::ST_WINIT:
            begin
                // lower bound may go negative: then it is always met
                lo_reg       <= lrbc_pkg::WIN_W'(width_reg) - lrbc_pkg::WIN_W'(width_tol_reg);
                lo2_reg      <= '0;
                hi2_reg      <= '0;
                walk_idx_reg <= '0;
                sum_x_reg    <= '0;
                sum_y_reg    <= '0;
                used_reg     <= '0;
            end
            lrbc_pkg::ST_WRD:
            begin
                lo2_reg <= lrbc_pkg::WSQ_W'(lo_reg) * lrbc_pkg::WSQ_W'(lo_reg);
                hi2_reg <= (lrbc_pkg::WSQ_W'(width_reg) + lrbc_pkg::WSQ_W'(width_tol_reg))
                         * (lrbc_pkg::WSQ_W'(width_reg) + lrbc_pkg::WSQ_W'(width_tol_reg));
            end
            lrbc_pkg::ST_WDIFF:
            begin
                walk_ok_reg <= valid_reg[walk_idx_reg] && (ram_rdata.cnt == 2'd2);
                dx_reg <= lrbc_pkg::DIFF_W'(ram_rdata.sec.x) - lrbc_pkg::DIFF_W'(ram_rdata.high.x);
                dy_reg <= lrbc_pkg::DIFF_W'(ram_rdata.sec.y) - lrbc_pkg::DIFF_W'(ram_rdata.high.y);
                dz_reg <= lrbc_pkg::DIFF_W'(ram_rdata.sec.z) - lrbc_pkg::DIFF_W'(ram_rdata.high.z);
                mx_reg <= lrbc_pkg::DIFF_W'(ram_rdata.sec.x) + lrbc_pkg::DIFF_W'(ram_rdata.high.x);
                my_reg <= lrbc_pkg::DIFF_W'(ram_rdata.sec.y) + lrbc_pkg::DIFF_W'(ram_rdata.high.y);
            end
            lrbc_pkg::ST_WSQ:
            begin
                dxx_reg <= lrbc_pkg::DSQ_W'(dx_reg * dx_reg);
                dyy_reg <= lrbc_pkg::DSQ_W'(dy_reg * dy_reg);
                dzz_reg <= lrbc_pkg::DSQ_W'(dz_reg * dz_reg);
            end
            lrbc_pkg::ST_WACC:
            begin
                if (walk_ok_reg && edge_ok)
                begin
                    sum_x_reg <= sum_x_reg + lrbc_pkg::SUM_W'(mx_reg);
                    sum_y_reg <= sum_y_reg + lrbc_pkg::SUM_W'(my_reg);
                    used_reg  <= used_reg + 1'b1;
                end
                walk_idx_reg <= walk_idx_reg + 1'b1;
            end
            lrbc_pkg::ST_DINIT:
            begin
                negx_reg    <= sum_x_reg[lrbc_pkg::SUM_W-1];
                negy_reg    <= sum_y_reg[lrbc_pkg::SUM_W-1];
                qx_reg      <= sum_x_reg[lrbc_pkg::SUM_W-1] ? lrbc_pkg::SUM_W'(-sum_x_reg)
                                                            : lrbc_pkg::SUM_W'(sum_x_reg);
                qy_reg      <= sum_y_reg[lrbc_pkg::SUM_W-1] ? lrbc_pkg::SUM_W'(-sum_y_reg)
                                                            : lrbc_pkg::SUM_W'(sum_y_reg);
                remx_reg    <= '0;
                remy_reg    <= '0;
                divisor_reg <= {used_reg, 1'b0};
                divc_reg    <= '0;
            end
            lrbc_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if ({remx_reg[lrbc_pkg::REM_W-2:0], qx_reg[lrbc_pkg::SUM_W-1]}
                    >= lrbc_pkg::REM_W'(divisor_reg))
                begin
                    remx_reg <= {remx_reg[lrbc_pkg::REM_W-2:0], qx_reg[lrbc_pkg::SUM_W-1]}
                              - lrbc_pkg::REM_W'(divisor_reg);
                    qx_reg   <= {qx_reg[lrbc_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    remx_reg <= {remx_reg[lrbc_pkg::REM_W-2:0], qx_reg[lrbc_pkg::SUM_W-1]};
                    qx_reg   <= {qx_reg[lrbc_pkg::SUM_W-2:0], 1'b0};
                end
                if ({remy_reg[lrbc_pkg::REM_W-2:0], qy_reg[lrbc_pkg::SUM_W-1]}
                    >= lrbc_pkg::REM_W'(divisor_reg))
                begin
                    remy_reg <= {remy_reg[lrbc_pkg::REM_W-2:0], qy_reg[lrbc_pkg::SUM_W-1]}
                              - lrbc_pkg::REM_W'(divisor_reg);
                    qy_reg   <= {qy_reg[lrbc_pkg::SUM_W-2:0], 1'b1};
                end
                else
                begin
                    remy_reg <= {remy_reg[lrbc_pkg::REM_W-2:0], qy_reg[lrbc_pkg::SUM_W-1]};
                    qy_reg   <= {qy_reg[lrbc_pkg::SUM_W-2:0], 1'b0};
                end
                divc_reg <= divc_reg + 1'b1;
            end
            lrbc_pkg::ST_DONE:
            begin
                if (!out_valid_reg)
                begin
                    if (used_reg == '0)
                    begin
                        out_x_reg <= '0;
                        out_y_reg <= '0;
                    end
                    else
                    begin
                        out_x_reg <= negx_reg ? CB'(-qx_reg) : CB'(qx_reg);
                        out_y_reg <= negy_reg ? CB'(-qy_reg) : CB'(qy_reg);
                    end
                    out_used_reg  <= (used_reg > lrbc_pkg::USED_W'(lrbc_pkg::USED_MAX))
                                     ? 7'(lrbc_pkg::USED_MAX) : used_reg[6:0];
                    out_found_reg <= (used_reg != '0);
                end
            end
            default:
            begin
                walk_ok_reg <= walk_ok_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
        (pt.valid && pt.ready) |=> (state_reg == lrbc_pkg::ST_MUL))
        else $error("accepted point did not start the item sequence");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ctr.valid) |-> ($past(state_reg) == lrbc_pkg::ST_DONE))
        else $error("result appeared outside the frame completion");

    a_counts_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lrbc_pkg::ST_DONE && !out_valid_reg) |=> (valid_reg == '0))
        else $error("ring counts not cleared after frame");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ring_ok_reg && present_reg && state_reg == lrbc_pkg::ST_UPD))
        else $error("ring entry written for a dropped point");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for lidar_ring_board_center_core
// Sends lidar point transactions under random backpressure and gaps. Each
// frame-end result is checked against a predictor with per-ring plane points.
// Configuration is rewritten between phases; the settings include the extremes.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = lrbc_pkg::COORD_BITS;
    localparam int NR = lrbc_pkg::RING_COUNT;

    typedef struct {
        logic signed [CB-1:0]          x;
        logic signed [CB-1:0]          y;
        logic signed [CB-1:0]          z;
        logic [lrbc_pkg::RING_IW-1:0]  ring;
        bit                            present;
        bit                            fe;
    } lidar_point_t;

    typedef struct {
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic [6:0]           used;
        bit                   found;
    } board_center_t;

    typedef struct {
        lidar_point_t  p;
        bit            has_exp;
        board_center_t e;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [lrbc_pkg::CFG_IW-1:0] cfg_index = '0;
    logic [lrbc_pkg::CFG_DW-1:0] cfg_data = '0;

    lrbc_point_if  pt();
    lrbc_center_if ctr();

    lidar_ring_board_center_core DUT (
        .clk(clk), .rst_n(rst_n), .pt(pt.sink), .ctr(ctr.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    longint nrm_a, nrm_b, nrm_c, nrm_ofs, plane_tol, board_w, board_wtol;
    int     ring_cnt [NR];
    longint low_x [NR], low_y [NR], low_z [NR];
    longint sec_x [NR], sec_y [NR], sec_z [NR];
    longint top_x [NR], top_y [NR], top_z [NR];

    board_center_t centers_due[$];
    int  errors = 0;
    int  items_sent = 0;
    int  frames_sent = 0;
    int  boards_found = 0;
    bit  calm = 1'b0;
    int  hold_cycles = 0;
    board_center_t directed_exp;

    function automatic bit on_plane(longint x, longint y, longint z);
        longint r, ar, n2, rhs;
        r = nrm_a * x + nrm_b * y + nrm_c * z + nrm_ofs;
        ar = (r < 0) ? -r : r;
        n2 = nrm_a * nrm_a + nrm_b * nrm_b + nrm_c * nrm_c;
        rhs = plane_tol * plane_tol * n2;
        if (ar >= (64'sd1 <<< 27))
            return 1'b0;
        return ar * ar < rhs;
    endfunction

    function automatic bit edge_in_window(int i);
        longint dx, dy, dz, d2, lo, hi;
        dx = sec_x[i] - top_x[i];
        dy = sec_y[i] - top_y[i];
        dz = sec_z[i] - top_z[i];
        d2 = dx * dx + dy * dy + dz * dz;
        lo = board_w - board_wtol;
        hi = board_w + board_wtol;
        return ((lo < 0) || (d2 > lo * lo)) && (d2 < hi * hi);
    endfunction

    // update ring extremes; returns 1 with the frame's center on frame end
    function automatic bit predict_center(lidar_point_t p, output board_center_t c);
        longint x, y, z, sx, sy;
        int r, used;
        x = p.x; y = p.y; z = p.z; r = p.ring;
        sx = 0; sy = 0; used = 0;
        c = '{0, 0, 0, 0};
        if (p.present && r < NR && on_plane(x, y, z))
        begin
            if (ring_cnt[r] == 0)
            begin
                low_x[r] = x; low_y[r] = y; low_z[r] = z;
                top_x[r] = x; top_y[r] = y; top_z[r] = z;
                ring_cnt[r] = 1;
            end
            else
            begin
                if (y < low_y[r])
                begin
                    sec_x[r] = low_x[r]; sec_y[r] = low_y[r]; sec_z[r] = low_z[r];
                    low_x[r] = x; low_y[r] = y; low_z[r] = z;
                end
                else if (ring_cnt[r] == 1 || y < sec_y[r])
                begin
                    sec_x[r] = x; sec_y[r] = y; sec_z[r] = z;
                end
                if (y >= top_y[r])
                begin
                    top_x[r] = x; top_y[r] = y; top_z[r] = z;
                end
                ring_cnt[r] = 2;
            end
        end
        if (!p.fe)
            return 1'b0;
        for (int i = 0; i < NR; i++)
        begin
            if (ring_cnt[i] >= 2 && edge_in_window(i))
            begin
                sx += sec_x[i] + top_x[i];
                sy += sec_y[i] + top_y[i];
                used++;
            end
            ring_cnt[i] = 0;
        end
        if (used > 0)
        begin
            c.cx = CB'(sx / (2 * used));
            c.cy = CB'(sy / (2 * used));
        end
        c.used = (used > 127) ? 7'd127 : 7'(used);
        c.found = (used > 0);
        return 1'b1;
    endfunction

    // hold the write enable; the caller drops it after the last write
    task automatic write_reg(lrbc_pkg::cfg_idx_t idx, longint v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[lrbc_pkg::CFG_DW-1:0];
        @(posedge clk);
        case (idx)
            lrbc_pkg::CFG_PLANE_A:   nrm_a = longint'($signed(v[15:0]));
            lrbc_pkg::CFG_PLANE_B:   nrm_b = longint'($signed(v[15:0]));
            lrbc_pkg::CFG_PLANE_C:   nrm_c = longint'($signed(v[15:0]));
            lrbc_pkg::CFG_PLANE_OFS: nrm_ofs = longint'($signed(v[17:0]));
            lrbc_pkg::CFG_PLANE_TOL: plane_tol = v & 64'h3FF;
            lrbc_pkg::CFG_WIDTH:     board_w = v & 64'hFFF;
            lrbc_pkg::CFG_WIDTH_TOL: board_wtol = v & 64'h3FF;
            default: ;
        endcase
    endtask

    // drive one transaction, hold until accepted, then predict
    task automatic send_point(lidar_point_t p);
        board_center_t c;
        if (!calm && $urandom_range(99) < 8)
        begin
            pt.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 50)
                @(posedge clk);
        end
        pt.valid <= 1'b1;
        pt.point_x <= p.x;
        pt.point_y <= p.y;
        pt.point_z <= p.z;
        pt.ring_index <= p.ring;
        pt.point_present <= p.present;
        pt.frame_end <= p.fe;
        do
            @(posedge clk);
        while (!pt.ready);
        items_sent++;
        if (predict_center(p, c))
        begin
            centers_due = {centers_due, c};
            frames_sent++;
        end
    endtask

    task automatic wait_idle();
        pt.valid <= 1'b0;
        while (centers_due.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic signed [CB-1:0] clamp_coord(longint v);
        if (v > 131071)
            return CB'(131071);
        if (v < -131072)
            return CB'(-131072);
        return CB'(v);
    endfunction

    function automatic longint pick_signed(longint lo, longint hi);
        return lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    // new plane and window settings, extremes now and then
    task automatic pick_config();
        longint a, ofs;
        int mode;
        mode = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0: a = -32768;
            1: a = 32767;
            default: a = pick_signed(-32768, 32767);
        endcase
        if (a == 0)
            a = 1;
        ofs = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? 131071 : -131072)
                                          : pick_signed(-131072, 131071);
        write_reg(lrbc_pkg::CFG_PLANE_A, (mode == 0) ? 0 : a);
        write_reg(lrbc_pkg::CFG_PLANE_B, (mode == 1) ? pick_signed(-32768, 32767) : 0);
        write_reg(lrbc_pkg::CFG_PLANE_C, (mode == 1) ? pick_signed(-32768, 32767) : 0);
        write_reg(lrbc_pkg::CFG_PLANE_OFS, ofs);
        case ($urandom_range(0, 5))
            0: write_reg(lrbc_pkg::CFG_PLANE_TOL, 0);
            1: write_reg(lrbc_pkg::CFG_PLANE_TOL, 1023);
            default: write_reg(lrbc_pkg::CFG_PLANE_TOL, $urandom_range(1, 300));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(lrbc_pkg::CFG_WIDTH, 1);
            1: write_reg(lrbc_pkg::CFG_WIDTH, 4095);
            default: write_reg(lrbc_pkg::CFG_WIDTH, $urandom_range(100, 2000));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(lrbc_pkg::CFG_WIDTH_TOL, 0);
            1: write_reg(lrbc_pkg::CFG_WIDTH_TOL, 1023);
            default: write_reg(lrbc_pkg::CFG_WIDTH_TOL, $urandom_range(5, 200));
        endcase
        cfg_we <= 1'b0;
    endtask

    function automatic lidar_point_t noise_point();
        lidar_point_t p;
        p.x = CB'($urandom);
        p.y = CB'($urandom);
        p.z = CB'($urandom);
        p.ring = lrbc_pkg::RING_IW'($urandom_range(0, 127));
        p.present = ($urandom_range(0, 3) != 0);
        p.fe = 1'b0;
        return p;
    endfunction

    // one frame of board-like rings plus noise, frame end on the last item
    task automatic board_frame();
        lidar_point_t p;
        longint x0, yc, z0, half, tj;
        int nrings, npts;
        nrings = $urandom_range(1, 6);
        x0 = (nrm_a != 0) ? -nrm_ofs / nrm_a : 0;
        tj = plane_tol + 2;
        for (int k = 0; k < nrings; k++)
        begin
            p.ring = lrbc_pkg::RING_IW'($urandom_range(0, NR - 1));
            yc = pick_signed(-100000, 100000);
            z0 = pick_signed(-3000, 3000);
            half = board_w / 2 + pick_signed(-(board_wtol + 20), board_wtol + 20);
            if (half < 0)
                half = 0;
            npts = $urandom_range(1, 5);
            for (int j = 0; j < npts; j++)
            begin
                p.x = clamp_coord(x0 + pick_signed(-tj, tj));
                case ($urandom_range(0, 2))
                    0: p.y = clamp_coord(yc - half);
                    1: p.y = clamp_coord(yc + half);
                    default: p.y = clamp_coord(yc + pick_signed(-half, half));
                endcase
                p.z = clamp_coord(z0 + pick_signed(-3, 3));
                p.present = 1'b1;
                p.fe = 1'b0;
                send_point(p);
                if ($urandom_range(99) < 12)
                    send_point(noise_point());
            end
        end
        p = noise_point();
        p.fe = 1'b1;
        if ($urandom_range(0, 1))
            p.present = 1'b0;
        send_point(p);
    endtask

    localparam int DIRECTED_ROWS = 15;
    stim_row_t directed [DIRECTED_ROWS];

    initial
    begin
        // empty frame right after reset, then default plane x=0, tolerance 50
        directed[0]  = '{'{0, 0, 0, 0, 0, 1}, 1, '{0, 0, 0, 0}};
        directed[1]  = '{'{10, -300, 5, 0, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[2]  = '{'{10, 300, 5, 0, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[3]  = '{'{-10, -400, 5, 0, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[4]  = '{'{49, -131072, 131071, 79, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[5]  = '{'{-49, 131071, -131072, 79, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[6]  = '{'{0, 10, 0, 80, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[7]  = '{'{0, 20, 0, 127, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[8]  = '{'{50, 0, 0, 1, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[9]  = '{'{-131072, 5, 0, 1, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[10] = '{'{131071, 6, 0, 1, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[11] = '{'{0, 0, 0, 2, 1, 0}, 0, '{0, 0, 0, 0}};
        directed[12] = '{'{0, 0, 0, 3, 0, 0}, 0, '{0, 0, 0, 0}};
        directed[13] = '{'{0, 350, 0, 0, 1, 1}, 0, '{0, 0, 0, 0}};
        // counts were cleared by the previous frame end
        directed[14] = '{'{0, 0, 0, 0, 0, 1}, 1, '{0, 0, 0, 0}};
    end

    initial
    begin
        pt.valid = 1'b0;
        pt.point_x = '0;
        pt.point_y = '0;
        pt.point_z = '0;
        pt.ring_index = '0;
        pt.point_present = 1'b0;
        pt.frame_end = 1'b0;
        nrm_a = 16384; nrm_b = 0; nrm_c = 0; nrm_ofs = 0;
        plane_tol = 50; board_w = 600; board_wtol = 50;
        foreach (ring_cnt[i])
            ring_cnt[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            int before_n;
            before_n = frames_sent;
            send_point(directed[i].p);
            if (directed[i].has_exp && frames_sent > before_n)
            begin
                directed_exp = centers_due[$];
                if (directed_exp.cx !== directed[i].e.cx ||
                    directed_exp.cy !== directed[i].e.cy ||
                    directed_exp.used !== directed[i].e.used ||
                    directed_exp.found !== directed[i].e.found)
                begin
                    $display("%0t: directed row %0d expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                             $time, i, directed[i].e.cx, directed[i].e.cy,
                             directed[i].e.used, directed[i].e.found, directed_exp.cx,
                             directed_exp.cy, directed_exp.used, directed_exp.found);
                    errors++;
                end
            end
        end
        wait_idle();

        for (int phase = 0; items_sent < 700; phase++)
        begin
            pick_config();
            calm = (phase == 3);
            if (phase == 2)
                hold_cycles = 1500;
            repeat ($urandom_range(2, 5))
                board_frame();
            wait_idle();
        end
        calm = 1'b0;

        $display("Covered %0d point transactions in %0d frames; %0d frames found a board.",
                 items_sent, frames_sent, boards_found);
        if (errors == 0)
            $display("[lidar_ring_board_center_core] OK");
        else
            $display("[lidar_ring_board_center_core] ERROR");
        $finish;
    end

    // result side: check accepted transactions, drive ready
    initial
    begin
        board_center_t e;
        ctr.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && ctr.valid && ctr.ready)
            begin
                if (centers_due.size() == 0)
                begin
                    $display("%0t: unexpected result x=%0d y=%0d used=%0d found=%0b",
                             $time, ctr.center_x, ctr.center_y, ctr.rings_used, ctr.found);
                    errors++;
                end
                else
                begin
                    e = centers_due.pop_front();
                    if (e.found)
                        boards_found++;
                    if (ctr.center_x !== e.cx || ctr.center_y !== e.cy ||
                        ctr.rings_used !== e.used || ctr.found !== e.found)
                    begin
                        $display("%0t: mismatch expected x=%0d y=%0d used=%0d found=%0b",
                                 $time, e.cx, e.cy, e.used, e.found);
                        $display("%0t:          actual   x=%0d y=%0d used=%0d found=%0b",
                                 $time, ctr.center_x, ctr.center_y, ctr.rings_used,
                                 ctr.found);
                        errors++;
                    end
                end
            end
            // hold off long enough for a second frame end to back up the input
            if (hold_cycles > 0)
            begin
                ctr.ready <= 1'b0;
                hold_cycles--;
            end
            else
                ctr.ready <= calm || ($urandom_range(99) >= 8);
        end
    end

    initial
    begin
        #3ms;
        $display("[lidar_ring_board_center_core] ERROR");
        $finish;
    end

endmodule
